// ===== sv/powerline_half_bit_frame_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// powerline half-bit frame receiver assertion macros
// shared property forms used by the receiver's checks
// ----------------------------------------------------------------------------
`ifndef POWERLINE_HALF_BIT_FRAME_RECEIVER_ASSERT_SVH
`define POWERLINE_HALF_BIT_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, masked during reset
`define PLR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define PLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/plr_pkg.sv =====
// ----------------------------------------------------------------------------
// plr_pkg
// types, phase codes, error codes and defaults for the half-bit receiver
// ----------------------------------------------------------------------------
package plr_pkg;

  // default message length in data bits
  localparam int unsigned MessageBitsDefault = 9;
  // width of the reported message field
  localparam int unsigned MsgOutWidth = 9;
  // quiet threshold after reset
  localparam logic [15:0] QuietThresholdReset = 16'd10;

  // receiver phase codes
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_START    = 3'd1;
  localparam logic [2:0] PH_DATA     = 3'd2;
  localparam logic [2:0] PH_PAUSE    = 3'd3;
  localparam logic [2:0] PH_ERROR    = 3'd4;
  localparam logic [2:0] PH_SUPPRESS = 3'd5;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_LEADIN = 2'd1;
  localparam logic [1:0] ERR_DATA   = 2'd2;
  localparam logic [1:0] ERR_PAUSE  = 2'd3;

  // lead-in and lead-out lengths
  localparam logic [7:0] StartOnes     = 8'd3;
  localparam logic [7:0] PauseZeros    = 8'd5;
  localparam logic [7:0] SuppressZeros = 8'd6;

  // configuration register addresses
  localparam logic [1:0] ADDR_QUIET_THRESHOLD = 2'd0;

  // receiver control state apart from the message shifter
  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  half_bit_count;
    logic        ready_flag;
    logic [1:0]  error_code;
    logic [15:0] silent_count;
  } rx_state_t;

  // one result item
  typedef struct packed {
    logic [MsgOutWidth-1:0] message;
    logic                   message_ready;
    logic                   ready_to_receive;
    logic                   quiet;
    logic [1:0]             last_error;
  } rx_result_t;

endpackage

// ===== sv/plr_if.sv =====
// ----------------------------------------------------------------------------
// plr item channels
// valid/ready channels for half-bit items and result items
// ----------------------------------------------------------------------------

// half-bit sample or take item
interface plr_sample_if;
  logic valid;
  logic ready;
  logic action;
  logic half_bit;

  modport source (output valid, output action, output half_bit, input ready);
  modport sink (input valid, input action, input half_bit, output ready);
endinterface

// receiver result item
interface plr_result_if;
  logic       valid;
  logic       ready;
  logic [8:0] message;
  logic       message_ready;
  logic       ready_to_receive;
  logic       quiet;
  logic [1:0] last_error;

  modport source (
    output valid, output message, output message_ready,
    output ready_to_receive, output quiet, output last_error, input ready
  );
  modport sink (
    input valid, input message, input message_ready,
    input ready_to_receive, input quiet, input last_error, output ready
  );
endinterface

// ===== sv/plr_core.sv =====
// ----------------------------------------------------------------------------
// plr_core
// next-state and result logic for one half-bit or take item
// ----------------------------------------------------------------------------
module plr_core
  import plr_pkg::*;
#(
  parameter int unsigned MESSAGE_BITS = MessageBitsDefault
) (
  input  rx_state_t               st,
  input  logic [MESSAGE_BITS-1:0] msg,
  input  logic                    action,
  input  logic                    half_bit,
  input  logic [15:0]             quiet_threshold,
  output rx_state_t               st_next,
  output logic [MESSAGE_BITS-1:0] msg_next,
  output rx_result_t              result
);

  localparam logic [7:0] DataHalfBits = 8'(2 * MESSAGE_BITS);

  logic [7:0]  hbc_inc;
  logic [7:0]  sup_count;
  logic [2:0]  ph;
  logic        idle;
  logic [MsgOutWidth-1:0] msg_out;

  // saturating half-bit count, unused phase codes fold to idle
  assign hbc_inc = (st.half_bit_count != 8'hFF) ? st.half_bit_count + 8'd1
                                                  : st.half_bit_count;
  assign ph = (st.phase > PH_SUPPRESS) ? PH_IDLE : st.phase;

  // suppression count: restarts on entry from the error phase
  assign sup_count = (ph == PH_ERROR) ? 8'd0 : hbc_inc;

  // phase machine
  always_comb begin
    st_next  = st;
    msg_next = msg;
    if (action) begin
      // take: report and clear the flag, nothing else moves
      st_next.ready_flag = 1'b0;
    end else begin
      if (half_bit) begin
        st_next.silent_count = 16'd0;
      end else if (st.silent_count != 16'hFFFF) begin
        st_next.silent_count = st.silent_count + 16'd1;
      end
      st_next.half_bit_count = hbc_inc;
      st_next.phase = ph;
      unique case (ph)
        PH_IDLE: begin
          st_next.half_bit_count = 8'd0;
          if (half_bit) begin
            st_next.phase      = PH_START;
            st_next.error_code = ERR_NONE;
          end
        end
        PH_START: begin
          if (!half_bit) begin
            if (hbc_inc == StartOnes) begin
              st_next.phase          = PH_DATA;
              st_next.half_bit_count = 8'd0;
              st_next.ready_flag     = 1'b0;
              msg_next               = '0;
            end else begin
              st_next.phase      = PH_ERROR;
              st_next.error_code = ERR_LEADIN;
            end
          end
        end
        PH_DATA: begin
          if (!hbc_inc[0] && (msg[0] == half_bit)) begin
            // second half equal to first: not a valid pair
            st_next.phase      = PH_ERROR;
            st_next.error_code = ERR_DATA;
          end else begin
            if (hbc_inc[0]) begin
              msg_next = MESSAGE_BITS'({msg, half_bit});
            end
            if (hbc_inc == DataHalfBits) begin
              st_next.phase          = PH_PAUSE;
              st_next.half_bit_count = 8'd0;
            end
          end
        end
        PH_PAUSE: begin
          if (half_bit) begin
            st_next.phase      = PH_ERROR;
            st_next.error_code = ERR_PAUSE;
          end else if (hbc_inc >= PauseZeros) begin
            st_next.phase      = PH_IDLE;
            st_next.ready_flag = 1'b1;
          end
        end
        PH_ERROR, PH_SUPPRESS: begin
          st_next.phase          = PH_SUPPRESS;
          st_next.half_bit_count = sup_count;
          if (half_bit) begin
            st_next.half_bit_count = 8'd0;
          end else if (sup_count == SuppressZeros) begin
            st_next.phase = PH_IDLE;
          end
        end
        default: begin
          st_next.phase = PH_IDLE;
        end
      endcase
    end
  end

  // message field, cut or zero-extended to the reported width
  for (genvar i = 0; i < MsgOutWidth; i++) begin : g_msg_out
    if (i < MESSAGE_BITS) begin : g_bit
      assign msg_out[i] = msg_next[i];
    end else begin : g_zero
      assign msg_out[i] = 1'b0;
    end
  end

  // result item
  assign idle = (st_next.phase == PH_IDLE) || (st_next.phase > PH_SUPPRESS);
  assign result.message          = msg_out;
  assign result.message_ready    = action ? st.ready_flag : st_next.ready_flag;
  assign result.ready_to_receive = idle;
  assign result.quiet            = idle && (st_next.silent_count > quiet_threshold);
  assign result.last_error       = st_next.error_code;

endmodule

// ===== sv/powerline_half_bit_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// powerline_half_bit_frame_receiver
// frame receiver fed one half-bit per mains zero crossing
// ----------------------------------------------------------------------------
//  channel   | role       | handshake      | carries
//  samples   | item in    | valid / ready  | action, half_bit
//  results   | item out   | valid / ready  | message, flags, last_error
//  apb       | config     | psel / penable | quiet_threshold at address 0
//
//  one item per cycle sustained while results are taken; an item passes the
//  input register, then the state and result update into the result register
//  reset clears phase, counters, message, flag, error and threshold (to 10)
//  a stalled result holds; the input register still takes one more item
// ----------------------------------------------------------------------------
`include "powerline_half_bit_frame_receiver_assert.svh"

module powerline_half_bit_frame_receiver
  import plr_pkg::*;
#(
  parameter int unsigned MESSAGE_BITS = MessageBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  plr_sample_if.sink          samples,
  plr_result_if.source        results,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [15:0]             quiet_threshold;
  rx_state_t               st;
  rx_state_t               st_next;
  logic [MESSAGE_BITS-1:0] msg;
  logic [MESSAGE_BITS-1:0] msg_next;
  rx_result_t              res_next;
  rx_result_t              res;
  logic                    res_valid;
  logic                    in_valid;
  logic                    in_action;
  logic                    in_half_bit;
  logic                    advance;
  logic                    cfg_write;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == ADDR_QUIET_THRESHOLD);
  assign prdata    = (paddr == ADDR_QUIET_THRESHOLD) ? {16'd0, quiet_threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_threshold <= QuietThresholdReset;
    end else if (cfg_write) begin
      quiet_threshold <= pwdata[15:0];
    end
  end

  // handshake: input register drains into the result register
  assign advance       = in_valid && (!res_valid || results.ready);
  assign samples.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.ready) begin
      in_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      in_action   <= samples.action;
      in_half_bit <= samples.half_bit;
    end
  end

  // state update
  plr_core #(
    .MESSAGE_BITS(MESSAGE_BITS)
  ) u_core (
    .st              (st),
    .msg             (msg),
    .action          (in_action),
    .half_bit        (in_half_bit),
    .quiet_threshold (quiet_threshold),
    .st_next         (st_next),
    .msg_next        (msg_next),
    .result          (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase          <= PH_IDLE;
      st.half_bit_count <= 8'd0;
      st.ready_flag     <= 1'b0;
      st.error_code     <= ERR_NONE;
      st.silent_count   <= 16'd0;
      msg               <= '0;
    end else if (advance) begin
      st  <= st_next;
      msg <= msg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign results.valid            = res_valid;
  assign results.message          = res.message;
  assign results.message_ready    = res.message_ready;
  assign results.ready_to_receive = res.ready_to_receive;
  assign results.quiet            = res.quiet;
  assign results.last_error       = res.last_error;

  // checks
  `PLR_ASSERT_NOW(a_data_count_in_range, clk, rst, st.phase == PH_DATA,
    st.half_bit_count < 8'(2 * MESSAGE_BITS), "data half-bit count past message end")
  `PLR_ASSERT_NOW(a_suppress_has_error, clk, rst, st.phase == PH_SUPPRESS,
    st.error_code != ERR_NONE, "suppression without an error code")
  `PLR_ASSERT_NEXT(a_stall_holds_state, clk, rst, in_valid && res_valid && !results.ready,
    $stable(st) && $stable(msg), "state moved while result stalled")

endmodule
